// ===== rtl/cosm_pkg.sv =====
// Package for the control output safety monitor: codes, limits and payload types.
`default_nettype none

package cosm_pkg;

    // Event codes carried in the operation field
    localparam logic [1:0] OP_VALIDATE = 2'd0;
    localparam logic [1:0] OP_SENSOR   = 2'd1;
    localparam logic [1:0] OP_REQUEST  = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    // Threat kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_UNSAFE = 2'd1;
    localparam logic [1:0] KIND_SPOOF  = 2'd2;
    localparam logic [1:0] KIND_RATE   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_OUTPUT_STEP   = 2'd0;
    localparam logic [1:0] REG_RISK_LIMIT        = 2'd1;
    localparam logic [1:0] REG_REQUEST_WINDOW_MS = 2'd2;

    // Configuration reset values
    localparam logic [14:0] MAX_OUTPUT_STEP_RST   = 15'd1000;
    localparam logic [14:0] RISK_LIMIT_RST        = 15'd70;
    localparam logic [15:0] REQUEST_WINDOW_MS_RST = 16'd1000;

    // Fixed thresholds and limits; the temperature and output limits are in hundredths
    localparam logic signed [15:0] HOT_LIMIT      = 16'sd15000;
    localparam logic signed [15:0] LOW_OUTPUT     = 16'sd8000;
    localparam logic [6:0]         LOW_CONFIDENCE = 7'd30;
    localparam logic [7:0]         REQUEST_CAP    = 8'd10;
    localparam logic [7:0]         TALLY_MAX      = 8'hFF;
    localparam logic [15:0]        TOTAL_MAX      = 16'hFFFF;
    localparam logic [2:0]         HEALTH_FULL    = 3'd5;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] sample_value;
        logic signed [15:0] temperature_now;
        logic signed [15:0] temperature_goal;
        logic signed [15:0] risk_value;
        logic [6:0]         confidence;
        logic signed [15:0] lower_limit;
        logic signed [15:0] upper_limit;
        logic [15:0]        max_sensor_step;
        logic [31:0]        time_ms;
    } cmd_t;

    typedef struct packed {
        logic        accepted;
        logic        safe_now;
        logic [1:0]  threat_kind;
        logic [15:0] threats_seen;
        logic [2:0]  sanity_fifths;
        logic [7:0]  requests_in_window;
    } rsp_t;

    // Magnitude of the difference of two signed 16-bit values
    function automatic logic [16:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic signed [16:0] ax;
        logic signed [16:0] bx;
        begin
            ax = 17'(a);
            bx = 17'(b);
            abs_diff = (ax > bx) ? 17'(ax - bx) : 17'(bx - ax);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/control_output_safety_monitor.sv =====
// Top level of the control output safety monitor: event checks and threat state.
//
// Usage:
//   Events enter on the cmd channel (cmd_valid / cmd_stall / cmd) and each one
//   gives exactly one result on the rsp channel (rsp_valid / rsp_stall / rsp).
//   A transfer happens at a rising edge with valid high and stall low.
//   An event is captured in an input register, checked against the monitor
//   state by compare logic and written to the result register, which
//   presents the result on the rsp channel. One event is taken every cycle
//   while the receiver keeps taking results.
//   The input and result registers part the two sides; when the receiver
//   stalls with a result waiting, an empty input register still takes one
//   event, and cmd_stall rises only once that register is also full.
//   Configuration registers are written through cfg_we / cfg_index / cfg_data; the user
//   must write them only while no event is in flight, as the block does not enforce it.
//   Reset (rst_n low, asynchronous) empties both registers, loads the
//   configuration defaults and returns the monitor to safe, no threat, full
//   health, zero counts and last output zero.
`default_nettype none

module control_output_safety_monitor (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_stall,
    input  wire cosm_pkg::cmd_t                cmd,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output cosm_pkg::rsp_t                     rsp,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [cosm_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Configuration
    logic [14:0] max_output_step_reg;
    logic [14:0] risk_limit_reg;
    logic [15:0] request_window_ms_reg;

    // Monitor state
    logic signed [15:0] last_output_reg, last_output_next;
    logic [1:0]         threat_reg, threat_next;
    logic [15:0]        total_reg, total_next;
    logic               safe_reg, safe_next;
    logic [2:0]         health_reg, health_next;
    logic [7:0]         tally_reg, tally_next;
    logic [31:0]        window_start_reg, window_start_next;

    // Pipeline registers
    logic               in_valid_reg;
    cosm_pkg::cmd_t     in_reg;
    logic               out_valid_reg;
    cosm_pkg::rsp_t     out_reg, out_next;

    logic               advance;
    logic               in_ready;
    logic               fire;

    // Check terms
    logic [16:0]        diff_last;
    logic               hot;
    logic               low_out;
    logic               unsafe_heur;
    logic               step_too_big;
    logic               risk_high;
    logic               out_of_range;
    logic               sensor_jump;
    logic [31:0]        elapsed;
    logic               in_window;
    logic [7:0]         tally_inc;
    logic               ok;
    logic               raise;
    logic [1:0]         raise_kind;

    assign advance   = !out_valid_reg || !rsp_stall;
    assign in_ready  = !in_valid_reg || advance;
    assign fire      = in_valid_reg && advance;
    assign cmd_stall = !in_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_output_step_reg   <= cosm_pkg::MAX_OUTPUT_STEP_RST;
            risk_limit_reg        <= cosm_pkg::RISK_LIMIT_RST;
            request_window_ms_reg <= cosm_pkg::REQUEST_WINDOW_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cosm_pkg::REG_MAX_OUTPUT_STEP:   max_output_step_reg <= cfg_data[14:0];
                cosm_pkg::REG_RISK_LIMIT:        risk_limit_reg <= cfg_data[14:0];
                cosm_pkg::REG_REQUEST_WINDOW_MS: request_window_ms_reg <= cfg_data[15:0];
                default:                         ;
            endcase
        end
    end

    // Compare terms shared by the event checks
    always_comb
    begin
        diff_last    = cosm_pkg::abs_diff(in_reg.sample_value, last_output_reg);
        hot          = in_reg.temperature_now > in_reg.temperature_goal;
        low_out      = in_reg.sample_value < cosm_pkg::LOW_OUTPUT;
        unsafe_heur  = (in_reg.temperature_now > cosm_pkg::HOT_LIMIT && low_out) ||
                       (in_reg.confidence < cosm_pkg::LOW_CONFIDENCE && hot && low_out);
        step_too_big = diff_last > {2'b00, max_output_step_reg};
        risk_high    = 17'(in_reg.risk_value) > $signed({2'b00, risk_limit_reg}) &&
                       in_reg.sample_value < last_output_reg && hot;
        out_of_range = in_reg.sample_value < in_reg.lower_limit ||
                       in_reg.sample_value > in_reg.upper_limit;
        sensor_jump  = last_output_reg != 16'sd0 &&
                       diff_last > {1'b0, in_reg.max_sensor_step};
        elapsed      = in_reg.time_ms - window_start_reg;
        in_window    = elapsed < {16'd0, request_window_ms_reg};
        tally_inc    = (tally_reg == cosm_pkg::TALLY_MAX) ? tally_reg : tally_reg + 8'd1;
    end

    // Decide the event outcome and the next monitor state
    always_comb
    begin
        ok                = 1'b1;
        raise             = 1'b0;
        raise_kind        = cosm_pkg::KIND_NONE;
        last_output_next  = last_output_reg;
        threat_next       = threat_reg;
        total_next        = total_reg;
        safe_next         = safe_reg;
        health_next       = health_reg;
        tally_next        = tally_reg;
        window_start_next = window_start_reg;

        case (in_reg.operation)
            cosm_pkg::OP_VALIDATE:
            begin
                if (unsafe_heur)
                begin
                    raise      = 1'b1;
                    raise_kind = cosm_pkg::KIND_UNSAFE;
                    ok         = 1'b0;
                end
                else if (step_too_big)
                begin
                    ok = 1'b0;
                end
                else if (risk_high)
                begin
                    raise      = 1'b1;
                    raise_kind = cosm_pkg::KIND_UNSAFE;
                    ok         = 1'b0;
                end
                else
                begin
                    last_output_next = in_reg.sample_value;
                end
            end
            cosm_pkg::OP_SENSOR:
            begin
                if (out_of_range || sensor_jump)
                begin
                    raise      = 1'b1;
                    raise_kind = cosm_pkg::KIND_SPOOF;
                    ok         = 1'b0;
                end
            end
            cosm_pkg::OP_REQUEST:
            begin
                if (in_window)
                begin
                    tally_next = tally_inc;
                    if (tally_inc > cosm_pkg::REQUEST_CAP)
                    begin
                        raise      = 1'b1;
                        raise_kind = cosm_pkg::KIND_RATE;
                        ok         = 1'b0;
                    end
                end
                else
                begin
                    tally_next        = 8'd1;
                    window_start_next = in_reg.time_ms;
                end
            end
            cosm_pkg::OP_CLEAR:
            begin
                if (total_reg != 16'd0)
                begin
                    threat_next = cosm_pkg::KIND_NONE;
                    safe_next   = 1'b1;
                    health_next = cosm_pkg::HEALTH_FULL;
                    tally_next  = 8'd0;
                end
            end
            default:
            begin
                ok = 1'b1;
            end
        endcase

        // Raise a threat: record kind, count it, drop health by one fifth
        if (raise)
        begin
            threat_next = raise_kind;
            safe_next   = 1'b0;
            if (total_reg != cosm_pkg::TOTAL_MAX)
            begin
                total_next = total_reg + 16'd1;
            end
            if (health_reg != 3'd0)
            begin
                health_next = health_reg - 3'd1;
            end
        end

        out_next.accepted           = ok;
        out_next.safe_now           = safe_next;
        out_next.threat_kind        = threat_next;
        out_next.threats_seen       = total_next;
        out_next.sanity_fifths      = health_next;
        out_next.requests_in_window = tally_next;
    end

    // Advance the input register and the monitor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_output_reg  <= 16'sd0;
            threat_reg       <= cosm_pkg::KIND_NONE;
            total_reg        <= 16'd0;
            safe_reg         <= 1'b1;
            health_reg       <= cosm_pkg::HEALTH_FULL;
            tally_reg        <= 8'd0;
            window_start_reg <= 32'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                last_output_reg  <= last_output_next;
                threat_reg       <= threat_next;
                total_reg        <= total_next;
                safe_reg         <= safe_next;
                health_reg       <= health_next;
                tally_reg        <= tally_next;
                window_start_reg <= window_start_next;
            end
        end
    end

    // Capture payloads; hold them while the stage is blocked
    always_ff @(posedge clk)
    begin
        if (in_ready && cmd_valid)
        begin
            in_reg <= cmd;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTH
    // Health never rises above full
    a_health_range: assert property (@(posedge clk) disable iff (!rst_n)
        health_reg <= cosm_pkg::HEALTH_FULL)
        else $error("health score above full");

    // Safe exactly when no threat kind is held
    a_safe_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        safe_reg == (threat_reg == cosm_pkg::KIND_NONE))
        else $error("safe flag disagrees with threat kind");

    // An unsafe state always has at least one counted threat
    a_unsafe_counted: assert property (@(posedge clk) disable iff (!rst_n)
        !safe_reg |-> total_reg != 16'd0)
        else $error("threat active with zero count");

    // Stall the input only when both registers are full and the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (rsp_valid && rsp_stall && in_valid_reg))
        else $error("input stalled without a blocked output");

    // Threat count never falls
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= $past(total_reg))
        else $error("threat count decreased");
`endif

endmodule

`default_nettype wire

// ===== dv/cosm_status_checker.sv =====
// Status checker for the safety monitor: predicts each result and compares it field by field.
`timescale 1ns / 100ps

module cosm_status_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  logic                            cmd_stall,
    input  cosm_pkg::cmd_t                  cmd,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  cosm_pkg::rsp_t                  rsp,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [cosm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);

    // Shadow configuration
    logic [14:0] step_limit;
    logic [14:0] risk_cap;
    logic [15:0] window_len;

    // Shadow monitor state
    logic signed [15:0] last_out;
    logic [1:0]         threat_now;
    logic [15:0]        raised_total;
    logic               safe_bit;
    logic [2:0]         health;
    logic [7:0]         tally;
    logic [31:0]        window_t0;

    cosm_pkg::rsp_t expected_status[$];
    cosm_pkg::rsp_t want_status;

    // Count a failure; keep the log short when the block is badly broken
    task automatic report_mismatch(input string what);
        fail_count = fail_count + 1;
        if (fail_count <= 200)
            $display("%0t mismatch: %s", $time, what);
    endtask

    function automatic void raise_threat(input logic [1:0] kind);
        threat_now = kind;
        if (raised_total != cosm_pkg::TOTAL_MAX)
            raised_total = raised_total + 16'd1;
        safe_bit = 1'b0;
        if (health != 3'd0)
            health = health - 3'd1;
    endfunction

    // Apply one event to the shadow state and return the status it gives
    function automatic cosm_pkg::rsp_t assess_event(input cosm_pkg::cmd_t ev);
        cosm_pkg::rsp_t verdict;
        int          sample;
        int          previous;
        int          risk;
        int          distance;
        logic        hot;
        logic        low_out;
        logic [31:0] elapsed;

        verdict  = '0;
        verdict.accepted = 1'b1;
        sample   = $signed(ev.sample_value);
        previous = int'(last_out);
        risk     = $signed(ev.risk_value);
        distance = (sample > previous) ? sample - previous : previous - sample;
        hot      = $signed(ev.temperature_now) > $signed(ev.temperature_goal);
        low_out  = $signed(ev.sample_value) < cosm_pkg::LOW_OUTPUT;

        case (ev.operation)
            cosm_pkg::OP_VALIDATE:
            begin
                if (($signed(ev.temperature_now) > cosm_pkg::HOT_LIMIT && low_out) ||
                    (ev.confidence < cosm_pkg::LOW_CONFIDENCE && hot && low_out))
                begin
                    raise_threat(cosm_pkg::KIND_UNSAFE);
                    verdict.accepted = 1'b0;
                end
                else if (distance > int'(step_limit))
                    verdict.accepted = 1'b0;
                else if (risk > int'(risk_cap) && sample < previous && hot)
                begin
                    raise_threat(cosm_pkg::KIND_UNSAFE);
                    verdict.accepted = 1'b0;
                end
                else
                    last_out = ev.sample_value;
            end
            cosm_pkg::OP_SENSOR:
            begin
                if ($signed(ev.sample_value) < $signed(ev.lower_limit) ||
                    $signed(ev.sample_value) > $signed(ev.upper_limit))
                begin
                    raise_threat(cosm_pkg::KIND_SPOOF);
                    verdict.accepted = 1'b0;
                end
                else if (previous != 0 && distance > int'(ev.max_sensor_step))
                begin
                    raise_threat(cosm_pkg::KIND_SPOOF);
                    verdict.accepted = 1'b0;
                end
            end
            cosm_pkg::OP_REQUEST:
            begin
                elapsed = ev.time_ms - window_t0;
                if (elapsed < 32'(window_len))
                begin
                    if (tally != cosm_pkg::TALLY_MAX)
                        tally = tally + 8'd1;
                    if (tally > cosm_pkg::REQUEST_CAP)
                    begin
                        raise_threat(cosm_pkg::KIND_RATE);
                        verdict.accepted = 1'b0;
                    end
                end
                else
                begin
                    tally     = 8'd1;
                    window_t0 = ev.time_ms;
                end
            end
            default:
            begin
                // Clearing only acts once a threat has ever been raised
                if (raised_total != 16'd0)
                begin
                    threat_now = cosm_pkg::KIND_NONE;
                    safe_bit   = 1'b1;
                    health     = cosm_pkg::HEALTH_FULL;
                    tally      = 8'd0;
                end
            end
        endcase

        verdict.safe_now           = safe_bit;
        verdict.threat_kind        = threat_now;
        verdict.threats_seen       = raised_total;
        verdict.sanity_fifths      = health;
        verdict.requests_in_window = tally;
        return verdict;
    endfunction

    // Track configuration, predict on each event transfer, compare on each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_limit   = cosm_pkg::MAX_OUTPUT_STEP_RST;
            risk_cap     = cosm_pkg::RISK_LIMIT_RST;
            window_len   = cosm_pkg::REQUEST_WINDOW_MS_RST;
            last_out     = '0;
            threat_now   = cosm_pkg::KIND_NONE;
            raised_total = '0;
            safe_bit     = 1'b1;
            health       = cosm_pkg::HEALTH_FULL;
            tally        = '0;
            window_t0    = '0;
            fail_count   = 0;
            expected_status.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cosm_pkg::REG_MAX_OUTPUT_STEP:   step_limit = cfg_data[14:0];
                    cosm_pkg::REG_RISK_LIMIT:        risk_cap   = cfg_data[14:0];
                    cosm_pkg::REG_REQUEST_WINDOW_MS: window_len = cfg_data[15:0];
                    default:                         ;
                endcase
            end

            if (cmd_valid && !cmd_stall)
                expected_status.push_back(assess_event(cmd));

            if (rsp_valid && !rsp_stall)
            begin
                if (expected_status.size() == 0)
                    report_mismatch("result transfer with no event waiting");
                else
                begin
                    want_status = expected_status.pop_front();
                    if (rsp.accepted !== want_status.accepted)
                        report_mismatch($sformatf("accepted got %0d want %0d",
                                                  rsp.accepted, want_status.accepted));
                    if (rsp.safe_now !== want_status.safe_now)
                        report_mismatch($sformatf("safe_now got %0d want %0d",
                                                  rsp.safe_now, want_status.safe_now));
                    if (rsp.threat_kind !== want_status.threat_kind)
                        report_mismatch($sformatf("threat_kind got %0d want %0d",
                                                  rsp.threat_kind, want_status.threat_kind));
                    if (rsp.threats_seen !== want_status.threats_seen)
                        report_mismatch($sformatf("threats_seen got %0d want %0d",
                                                  rsp.threats_seen, want_status.threats_seen));
                    if (rsp.sanity_fifths !== want_status.sanity_fifths)
                        report_mismatch($sformatf("sanity_fifths got %0d want %0d",
                                                  rsp.sanity_fifths, want_status.sanity_fifths));
                    if (rsp.requests_in_window !== want_status.requests_in_window)
                        report_mismatch($sformatf("requests_in_window got %0d want %0d",
                                                  rsp.requests_in_window,
                                                  want_status.requests_in_window));
                end
            end

            pending <= expected_status.size();
        end
    end

endmodule

// ===== dv/tb_control_output_safety_monitor.sv =====
// Testbench top for the safety monitor: drives events and configuration, gives the verdict.
`timescale 1ns / 100ps

module tb_control_output_safety_monitor;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cmd_valid = 1'b0;
    logic                            cmd_stall;
    cosm_pkg::cmd_t                  cmd       = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b0;
    cosm_pkg::rsp_t                  rsp;
    logic                            cfg_we    = 1'b0;
    logic [1:0]                      cfg_index = cosm_pkg::REG_MAX_OUTPUT_STEP;
    logic [cosm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    int                              fail_count;
    int                              pending;

    // Stimulus shaping state
    bit          calm          = 1'b0;
    int          recent_sample = 0;
    logic [31:0] now_ms        = '0;

    control_output_safety_monitor dut (.*);

    cosm_status_checker status_check (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic int clip16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // Benign event: in range, confident, not hot, wide sensor limits
    function automatic cosm_pkg::cmd_t base_event(input logic [1:0] op);
        cosm_pkg::cmd_t ev;
        ev                  = '0;
        ev.operation        = op;
        ev.temperature_now  = 16'(2000);
        ev.temperature_goal = 16'(2000);
        ev.confidence       = 7'd90;
        ev.lower_limit      = 16'(-32768);
        ev.upper_limit      = 16'(32767);
        ev.max_sensor_step  = 16'hFFFF;
        return ev;
    endfunction

    function automatic cosm_pkg::cmd_t random_event();
        cosm_pkg::cmd_t ev;
        ev.operation        = 2'($urandom_range(0, 3));
        ev.sample_value     = 16'($urandom);
        ev.temperature_now  = 16'($urandom);
        ev.temperature_goal = 16'($urandom);
        ev.risk_value       = 16'($urandom);
        ev.confidence       = 7'($urandom_range(0, 100));
        ev.lower_limit      = 16'($urandom);
        ev.upper_limit      = 16'($urandom);
        ev.max_sensor_step  = 16'($urandom);
        ev.time_ms          = $urandom;
        return ev;
    endfunction

    // Plausible traffic: ramps near the last proposal, sensors near it, request bursts
    function automatic cosm_pkg::cmd_t shaped_event();
        cosm_pkg::cmd_t ev;
        int   roll;
        int   value;
        int   spread;
        int   shift;
        ev   = random_event();
        roll = $urandom_range(0, 99);
        if (roll < 35)
        begin
            value = clip16(recent_sample + int'($urandom_range(0, 2400)) - 1200);
            recent_sample       = value;
            ev.operation        = cosm_pkg::OP_VALIDATE;
            ev.sample_value     = 16'(value);
            value               = int'($urandom_range(0, 17000)) - 1000;
            ev.temperature_now  = 16'(value);
            ev.temperature_goal = 16'(value + int'($urandom_range(0, 1000)) - 500);
            ev.risk_value       = 16'(int'($urandom_range(0, 300)) - 50);
            ev.confidence       = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 29))
                                                              : 7'($urandom_range(30, 100));
        end
        else if (roll < 60)
        begin
            value  = clip16(recent_sample + int'($urandom_range(0, 600)) - 300);
            spread = $urandom_range(0, 2000);
            // Now and then move the limits off the value
            shift  = ($urandom_range(0, 9) == 0) ? spread + int'($urandom_range(1, 200)) : 0;
            if ($urandom_range(0, 1) != 0)
                shift = -shift;
            ev.operation       = cosm_pkg::OP_SENSOR;
            ev.sample_value    = 16'(value);
            ev.lower_limit     = 16'(clip16(value - spread + shift));
            ev.upper_limit     = 16'(clip16(value + spread + shift));
            ev.max_sensor_step = 16'($urandom_range(0, 600));
        end
        else if (roll < 90)
        begin
            now_ms = now_ms + (($urandom_range(0, 9) == 0) ? $urandom_range(500, 3000)
                                                           : $urandom_range(0, 60));
            ev.operation = cosm_pkg::OP_REQUEST;
            ev.time_ms   = now_ms;
        end
        else
            ev.operation = cosm_pkg::OP_CLEAR;
        return ev;
    endfunction

    // Present one event and hold it until the transfer
    task automatic send_event(input cosm_pkg::cmd_t ev);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= ev;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    // Drop valid and wait until every result has been taken
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_config(input logic [14:0] step, input logic [14:0] risk,
                              input logic [15:0] window);
        cfg_we    <= 1'b1;
        cfg_index <= cosm_pkg::REG_MAX_OUTPUT_STEP;
        cfg_data  <= 16'(step);
        @(posedge clk);
        cfg_index <= cosm_pkg::REG_RISK_LIMIT;
        cfg_data  <= 16'(risk);
        @(posedge clk);
        cfg_index <= cosm_pkg::REG_REQUEST_WINDOW_MS;
        cfg_data  <= window;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side stall pattern
    initial
    begin : stall_gen
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else
                hold = pick_gap();
            rsp_stall <= (hold != 0);
        end
    end

    initial
    begin : stimulus
        cosm_pkg::cmd_t ev;
        int          n;
        int          phase;
        logic [14:0] step_cfg;
        logic [14:0] risk_cfg;
        logic [15:0] window_cfg;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Clear with no threat ever raised changes nothing
        send_event(base_event(cosm_pkg::OP_CLEAR));

        // Sensor rate test skipped while the last output is zero
        ev = base_event(cosm_pkg::OP_SENSOR);
        ev.sample_value    = 16'(30000);
        ev.max_sensor_step = 16'd0;
        send_event(ev);

        // Accepted action, extreme risk and full confidence
        ev = base_event(cosm_pkg::OP_VALIDATE);
        ev.sample_value     = 16'(500);
        ev.temperature_goal = 16'(2500);
        ev.risk_value       = 16'(32767);
        ev.confidence       = 7'd100;
        send_event(ev);

        // Too hot with a low output
        ev = base_event(cosm_pkg::OP_VALIDATE);
        ev.sample_value    = 16'(7000);
        ev.temperature_now = 16'(16000);
        send_event(ev);

        // Low confidence, above target, low output
        ev = base_event(cosm_pkg::OP_VALIDATE);
        ev.sample_value    = 16'(600);
        ev.temperature_now = 16'(3000);
        ev.confidence      = 7'd0;
        send_event(ev);

        // Ramp too large, refused without a threat
        ev = base_event(cosm_pkg::OP_VALIDATE);
        ev.sample_value     = 16'(32767);
        ev.temperature_now  = 16'(-32768);
        ev.temperature_goal = 16'(32767);
        ev.confidence       = 7'd100;
        send_event(ev);

        // Risky reduction while above target
        ev = base_event(cosm_pkg::OP_VALIDATE);
        ev.sample_value    = 16'(400);
        ev.temperature_now = 16'(3000);
        ev.risk_value      = 16'(71);
        send_event(ev);

        // Same reduction with the lowest risk passes
        ev.risk_value = 16'(-32768);
        send_event(ev);

        send_event(base_event(cosm_pkg::OP_CLEAR));

        // Sensor below its range
        ev = base_event(cosm_pkg::OP_SENSOR);
        ev.sample_value = 16'(100);
        ev.lower_limit  = 16'(200);
        ev.upper_limit  = 16'(300);
        send_event(ev);

        // Inverted limits refuse everything
        ev.sample_value = 16'(250);
        ev.lower_limit  = 16'(300);
        ev.upper_limit  = 16'(200);
        send_event(ev);

        // Sensor too far from the last output
        ev = base_event(cosm_pkg::OP_SENSOR);
        ev.sample_value    = 16'(900);
        ev.max_sensor_step = 16'd100;
        send_event(ev);

        // Full range sensor at the bottom value
        ev = base_event(cosm_pkg::OP_SENSOR);
        ev.sample_value = 16'(-32768);
        send_event(ev);

        send_event(base_event(cosm_pkg::OP_CLEAR));

        // Burst of requests past the cap
        for (n = 0; n < 11; n++)
        begin
            ev = base_event(cosm_pkg::OP_REQUEST);
            ev.time_ms = 32'd5000 + 32'(n);
            send_event(ev);
        end

        // Window arithmetic across the wrap
        ev = base_event(cosm_pkg::OP_REQUEST);
        ev.time_ms = 32'hFFFF_FFFF;
        send_event(ev);
        ev.time_ms = 32'd4;
        send_event(ev);
        now_ms = 32'd4;

        send_event(base_event(cosm_pkg::OP_CLEAR));

        // Random phases, each under its own configuration
        for (phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    step_cfg   = '0;
                    risk_cfg   = '0;
                    window_cfg = '0;
                end
                1:
                begin
                    step_cfg   = '1;
                    risk_cfg   = '1;
                    window_cfg = '1;
                end
                2:
                begin
                    step_cfg   = cosm_pkg::MAX_OUTPUT_STEP_RST;
                    risk_cfg   = cosm_pkg::RISK_LIMIT_RST;
                    window_cfg = cosm_pkg::REQUEST_WINDOW_MS_RST;
                end
                3:
                begin
                    step_cfg   = 15'($urandom_range(200, 3000));
                    risk_cfg   = 15'($urandom_range(0, 300));
                    window_cfg = 16'($urandom_range(100, 5000));
                end
                4:
                begin
                    step_cfg   = 15'd1;
                    risk_cfg   = '1;
                    window_cfg = 16'd1;
                end
                default:
                begin
                    step_cfg   = 15'($urandom);
                    risk_cfg   = 15'($urandom);
                    window_cfg = 16'($urandom);
                end
            endcase
            set_config(step_cfg, risk_cfg, window_cfg);

            // Long window: drive the request count to saturation
            if (window_cfg == 16'hFFFF)
            begin
                for (n = 0; n < 260; n++)
                begin
                    ev = base_event(cosm_pkg::OP_REQUEST);
                    now_ms = now_ms + 32'd1;
                    ev.time_ms = now_ms;
                    send_event(ev);
                end
            end

            for (n = 0; n < 180; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    calm = !calm;
                if ($urandom_range(0, 99) < 15)
                    send_event(random_event());
                else
                    send_event(shaped_event());
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
